>>> hdl/two_level_page_walk_macros.svh
// Assertion helpers for the page walk RTL.
`ifndef TWO_LEVEL_PAGE_WALK_MACROS_SVH
`define TWO_LEVEL_PAGE_WALK_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TLPW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define TLPW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tlpw_pkg.sv
package tlpw_pkg;

  // Table store depth; a power of two, so the word index is a plain bit slice.
  localparam int unsigned TABLE_WORDS = 4096;
  localparam int unsigned IDX_W       = $clog2(TABLE_WORDS);

  localparam int unsigned CFG_ADDR_W  = 5;
  localparam int unsigned LEVELS      = 4;

  localparam logic [2:0] REG_PAGING_ENABLE = 3'd0;
  localparam logic [2:0] REG_DIR_BASE0     = 3'd1;
  localparam logic [2:0] REG_DIR_BASE1     = 3'd2;
  localparam logic [2:0] REG_DIR_BASE2     = 3'd3;
  localparam logic [2:0] REG_DIR_BASE3     = 3'd4;

  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  localparam logic [31:0] OFFSET_MASK = 32'h0000_0FFF;

  typedef enum logic [1:0] {
    FAULT_NONE        = 2'd0,
    FAULT_NOT_PRESENT = 2'd1,
    FAULT_PROTECTION  = 2'd2
  } fault_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIR,
    ST_TBL,
    ST_HOLD
  } walk_state_e;

  typedef struct packed {
    logic [LEVELS-1:0]            paging_enable;
    logic [LEVELS-1:0][31:0]      dir_base;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [31:0]      wdata;
  } mem_req_t;

  // Valid bit, then privilege field against the access level.
  function automatic fault_e check_entry(logic [31:0] entry, logic [1:0] level);
    fault_e f;
    if (!entry[0]) begin
      f = FAULT_NOT_PRESENT;
    end else if (entry[2:1] < level) begin
      f = FAULT_PROTECTION;
    end else begin
      f = FAULT_NONE;
    end
    return f;
  endfunction

  function automatic logic [IDX_W-1:0] word_index(logic [31:0] byte_addr);
    return byte_addr[IDX_W+1:2];
  endfunction

endpackage

>>> hdl/tlpw_cfg_regs.sv
module tlpw_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tlpw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output tlpw_pkg::cfg_t                  cfg_o
);
  import tlpw_pkg::*;

  logic [LEVELS-1:0]       paging_enable_q;
  logic [LEVELS-1:0][31:0] dir_base_q;
  logic [2:0]              reg_idx;
  logic                    wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paging_enable_q <= '0;
      dir_base_q      <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PAGING_ENABLE: paging_enable_q <= pwdata[LEVELS-1:0];
        REG_DIR_BASE0:     dir_base_q[0]   <= pwdata;
        REG_DIR_BASE1:     dir_base_q[1]   <= pwdata;
        REG_DIR_BASE2:     dir_base_q[2]   <= pwdata;
        REG_DIR_BASE3:     dir_base_q[3]   <= pwdata;
        default: ; // unmapped, dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PAGING_ENABLE: prdata = {28'd0, paging_enable_q};
      REG_DIR_BASE0:     prdata = dir_base_q[0];
      REG_DIR_BASE1:     prdata = dir_base_q[1];
      REG_DIR_BASE2:     prdata = dir_base_q[2];
      REG_DIR_BASE3:     prdata = dir_base_q[3];
      default:           prdata = '0;
    endcase
  end

  assign cfg_o.paging_enable = paging_enable_q;
  assign cfg_o.dir_base      = dir_base_q;

endmodule

>>> hdl/tlpw_ram.sv
module tlpw_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

>>> hdl/tlpw_walker.sv
module tlpw_walker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tlpw_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [31:0]        address_i,
  input  logic [31:0]        table_word_i,
  input  logic [1:0]         priv_level_i,
  input  logic [2:0]         rights_i,
  output tlpw_pkg::mem_req_t mem_req_o,
  input  logic [31:0]        mem_rdata_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        phys_addr_o,
  output logic [1:0]         fault_o
);
  import tlpw_pkg::*;
  `include "two_level_page_walk_macros.svh"

  walk_state_e state_q, state_d;

  logic [31:0] addr_q;
  logic [1:0]  level_q;
  logic [2:0]  rights_q;

  logic [31:0] hold_addr_q;
  fault_e      hold_fault_q;

  logic        out_valid_q;
  logic [31:0] out_addr_q;
  fault_e      out_fault_q;

  logic        accept;
  logic        out_free;
  logic        done;
  logic [31:0] res_addr;
  fault_e      res_fault;
  fault_e      entry_fault;
  logic [31:0] dir_word;
  logic [31:0] tbl_word;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  assign dir_word = cfg_i.dir_base[priv_level_i] + {20'd0, address_i[31:22], 2'b00};
  // frame base has zero low bits, so the add is a concatenation
  assign tbl_word = {mem_rdata_i[31:12], addr_q[21:12], 2'b00};

  assign entry_fault = check_entry(mem_rdata_i, level_q);

  // result of the current step
  always_comb begin
    done      = 1'b0;
    res_addr  = '0;
    res_fault = FAULT_NONE;
    unique case (state_q)
      ST_IDLE: begin
        done     = accept && (op_i == OP_TRANSLATE) && !cfg_i.paging_enable[priv_level_i];
        res_addr = address_i;
      end
      ST_DIR: begin
        done      = (entry_fault != FAULT_NONE);
        res_fault = entry_fault;
      end
      ST_TBL: begin
        done = 1'b1;
        if (entry_fault != FAULT_NONE) begin
          res_fault = entry_fault;
        end else if ((mem_rdata_i[5:3] & rights_q) != rights_q) begin
          res_fault = FAULT_PROTECTION;
        end else begin
          res_addr = (mem_rdata_i & ~OFFSET_MASK) | (addr_q & OFFSET_MASK);
        end
      end
      ST_HOLD: ;
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (op_i == OP_TRANSLATE)) begin
          if (cfg_i.paging_enable[priv_level_i]) begin
            state_d = ST_DIR;
          end else if (!out_free) begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_DIR: begin
        if (entry_fault == FAULT_NONE) begin
          state_d = ST_TBL;
        end else begin
          state_d = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_TBL:  state_d = out_free ? ST_IDLE : ST_HOLD;
      ST_HOLD: state_d = out_free ? ST_IDLE : ST_HOLD;
      default: state_d = ST_IDLE;
    endcase
  end

  // memory port and input handshake
  always_comb begin
    in_ready_o      = (state_q == ST_IDLE);
    mem_req_o.en    = 1'b0;
    mem_req_o.we    = 1'b0;
    mem_req_o.addr  = word_index(dir_word);
    mem_req_o.wdata = table_word_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mem_req_o.we = (op_i == OP_WRITE);
          mem_req_o.en = (op_i == OP_WRITE) || cfg_i.paging_enable[priv_level_i];
          if (op_i == OP_WRITE) begin
            mem_req_o.addr = word_index(address_i);
          end
        end
      end
      ST_DIR: begin
        mem_req_o.en   = (entry_fault == FAULT_NONE);
        mem_req_o.addr = word_index(tbl_word);
      end
      ST_TBL:  ;
      ST_HOLD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((done || (state_q == ST_HOLD)) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q   <= address_i;
      level_q  <= priv_level_i;
      rights_q <= rights_i;
    end
    if (done && !out_free) begin
      hold_addr_q  <= res_addr;
      hold_fault_q <= res_fault;
    end
    if (out_free) begin
      if (state_q == ST_HOLD) begin
        out_addr_q  <= hold_addr_q;
        out_fault_q <= hold_fault_q;
      end else if (done) begin
        out_addr_q  <= res_addr;
        out_fault_q <= res_fault;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign phys_addr_o = out_addr_q;
  assign fault_o     = out_fault_q;

  `TLPW_ASSERT_NOW(a_write_only_on_accept, mem_req_o.en && mem_req_o.we,
    accept && (op_i == OP_WRITE), "table write outside an accepted write beat")
  `TLPW_ASSERT_NOW(a_hold_means_busy, state_q == ST_HOLD, out_valid_q,
    "result held while output register is free")
  `TLPW_ASSERT_NEXT(a_dir_read_issued, (state_q == ST_IDLE) && (state_d == ST_DIR),
    (state_q == ST_DIR) && $past(mem_req_o.en && !mem_req_o.we),
    "directory step without a read")
  `TLPW_ASSERT_NEXT(a_tbl_read_issued, (state_q == ST_DIR) && (state_d == ST_TBL),
    $past(mem_req_o.en && !mem_req_o.we), "table step without a read")
  `TLPW_ASSERT_NOW(a_fault_zero_addr, out_valid_q && (out_fault_q != FAULT_NONE),
    out_addr_q == 32'd0, "faulting result with non-zero address")

endmodule

>>> hdl/two_level_page_walk.sv
// Two-level (10/10/12) page table walk. A write beat (op 0) stores one table word.
// A translate beat with paging off for its level gives its result straight into the
// output register if that is free. With paging on, the directory read issues at
// acceptance and the table read in ST_DIR; a directory fault ends the walk there, else
// the result comes from ST_TBL, as set by the two dependent reads of the single-port,
// registered-read table RAM. A finished result waiting at the output does not block the
// next beat; a further result waits in a hold register. The table RAM has no reset and
// no clearing pass, so entries must be written before a walk reads them. Configuration
// is over the APB port, written by the user while idle; the block does not enforce it.
module two_level_page_walk (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tlpw_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            op_i,
  input  logic [31:0]                     address_i,
  input  logic [31:0]                     table_word_i,
  input  logic [1:0]                      priv_level_i,
  input  logic [2:0]                      rights_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [31:0]                     phys_addr_o,
  output logic [1:0]                      fault_o
);
  import tlpw_pkg::*;

  cfg_t        cfg;
  mem_req_t    mem_req;
  logic [31:0] mem_rdata;

  tlpw_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tlpw_ram #(
    .DEPTH (TABLE_WORDS),
    .WIDTH (32)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (mem_req.en),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

  tlpw_walker u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .address_i    (address_i),
    .table_word_i (table_word_i),
    .priv_level_i (priv_level_i),
    .rights_i     (rights_i),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .phys_addr_o  (phys_addr_o),
    .fault_o      (fault_o)
  );

endmodule
